### sv/binary_min_heap_queue_core_defines.svh
// Assertion macros for the heap queue checker.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define BMHQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bmhq_pkg.sv
package bmhq_pkg;

    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

endpackage

### sv/bmhq_ram.sv
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/binary_min_heap_queue_core.sv
// Binary min-heap priority queue of (key, tag) entries.
// Input channel (in_valid/in_ready): op selects insert (0) or extract-min (1);
// insert_key/insert_tag carry the entry for an insert.
// Output channel (out_valid/out_ready): one word per input word with status,
// the extracted entry (zero unless a successful extract) and entry_count.
// Entries live in one single-port-read RAM; the moving entry sits in a
// register and the hole walks the tree, one slot write per level.
// An insert starts the hole at the new last slot and climbs, moving each
// parent down while it is strictly larger; an extract reads the root and the
// last entry, then descends, reading the left and right children at each
// level. Empty and full cases go straight to the result. Once the result is
// taken, the block returns to idle before the next word is taken.
// The RAM read port (one read per cycle, registered) sets the per-level cost.
// One word is in flight at a time: in_ready is high only when idle, and a
// result holds on the output until out_ready takes it; a stalled receiver
// holds off the next input.
// Reset clears the entry count and control state; RAM contents are not
// cleared since slots beyond the count are never read.
module binary_min_heap_queue_core #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [KEY_BITS-1:0]                 insert_key,
    input  logic [TAG_BITS-1:0]                 insert_tag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bmhq_pkg::STATUS_W-1:0]       status,
    output logic [KEY_BITS-1:0]                 out_key,
    output logic [TAG_BITS-1:0]                 out_tag,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;
    localparam int DW = KEY_BITS + TAG_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_EX_TAKE,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [KEY_BITS-1:0]   cur_key_reg, cur_key_next;
    logic [TAG_BITS-1:0]   cur_tag_reg, cur_tag_next;
    logic [KEY_BITS-1:0]   child_key_reg, child_key_next;
    logic [TAG_BITS-1:0]   child_tag_reg, child_tag_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [KEY_BITS-1:0]   out_key_reg, out_key_next;
    logic [TAG_BITS-1:0]   out_tag_reg, out_tag_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DW-1:0]         ram_rdata;

    logic [KEY_BITS-1:0]   rd_key;
    logic [TAG_BITS-1:0]   rd_tag;
    logic [AW-1:0]         parent_idx;
    logic [LW-1:0]         lc_idx;
    logic [LW-1:0]         rc_idx;
    logic                  lc_ok;
    logic                  rc_ok;
    logic                  left_take;
    logic [KEY_BITS-1:0]   best_key;
    logic                  right_take;

    bmhq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key     = ram_rdata[DW-1:TAG_BITS];
    assign rd_tag     = ram_rdata[TAG_BITS-1:0];
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);
    assign lc_idx     = {1'b0, pos_reg, 1'b1};
    assign rc_idx     = lc_idx + LW'(1);
    assign lc_ok      = lc_idx < LW'(count_reg);
    assign rc_ok      = rc_idx < LW'(count_reg);
    // left child already known to be in range when we get to the compare
    assign left_take  = child_key_reg < cur_key_reg;
    assign best_key   = left_take ? child_key_reg : cur_key_reg;
    assign right_take = rc_ok && (rd_key < best_key);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        cur_key_next   = cur_key_reg;
        cur_tag_next   = cur_tag_reg;
        child_key_next = child_key_reg;
        child_tag_next = child_tag_reg;
        status_next    = status_reg;
        out_key_next   = out_key_reg;
        out_tag_next   = out_tag_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = {cur_key_reg, cur_tag_reg};
        ram_re         = 1'b0;
        ram_raddr      = parent_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next  = STATUS_OK;
                    out_key_next = '0;
                    out_tag_next = '0;
                    if (op == OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_key_next = insert_key;
                            cur_tag_next = insert_tag;
                            pos_next     = count_reg[AW-1:0];
                            count_next   = count_reg + CW'(1);
                            state_next   = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_EX_ROOT;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (rd_key > cur_key_reg)
                begin
                    // parent moves down into the hole
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EX_ROOT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                // count already decremented: it indexes the last entry
                ram_re       = 1'b1;
                ram_raddr    = count_reg[AW-1:0];
                out_key_next = rd_key;
                out_tag_next = rd_tag;
                state_next   = S_EX_TAKE;
            end
            S_EX_TAKE:
            begin
                cur_key_next = rd_key;
                cur_tag_next = rd_tag;
                pos_next     = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_LEFT;
                end
            end
            S_DN_LEFT:
            begin
                if (lc_ok)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = lc_idx[AW-1:0];
                    state_next = S_DN_RIGHT;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_RIGHT:
            begin
                ram_re         = rc_ok;
                ram_raddr      = rc_idx[AW-1:0];
                child_key_next = rd_key;
                child_tag_next = rd_tag;
                state_next     = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (right_take)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = rc_idx[AW-1:0];
                    state_next = S_DN_LEFT;
                end
                else if (left_take)
                begin
                    ram_wdata  = {child_key_reg, child_tag_reg};
                    pos_next   = lc_idx[AW-1:0];
                    state_next = S_DN_LEFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            status_reg  <= STATUS_OK;
            out_key_reg <= '0;
            out_tag_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
            out_key_reg <= out_key_next;
            out_tag_reg <= out_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cur_key_reg   <= cur_key_next;
        cur_tag_reg   <= cur_tag_next;
        child_key_reg <= child_key_next;
        child_tag_reg <= child_tag_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_DONE);
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_tag     = out_tag_reg;
    assign entry_count = count_reg;

endmodule

### sv/bmhq_checker.sv
`include "binary_min_heap_queue_core_defines.svh"

module bmhq_checker #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [bmhq_pkg::STATUS_W-1:0]       status,
    input logic [KEY_BITS-1:0]                 out_key,
    input logic [TAG_BITS-1:0]                 out_tag,
    input logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

    import bmhq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // one word in flight: never ready for input while a result is shown
    `BMHQ_ASSERT_IMPL(a_one_in_flight, clk, rst_n, out_valid, !in_ready, "ready while result pending")

    // a rejected word carries no entry
    `BMHQ_ASSERT_IMPL(a_reject_zero, clk, rst_n, out_valid && (status != STATUS_OK), (out_key == '0) && (out_tag == '0), "rejected word carries data")

    `BMHQ_ASSERT_IMPL(a_empty_count, clk, rst_n, out_valid && (status == STATUS_EMPTY), entry_count == '0, "empty status with entries held")

    `BMHQ_ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && (status == STATUS_FULL), entry_count == CW'(CAPACITY), "full status below capacity")

    // an accepted input leaves the block not ready in the cycle after the accept
    `BMHQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule

bind binary_min_heap_queue_core bmhq_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
) u_bmhq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_key     (out_key),
    .out_tag     (out_tag),
    .entry_count (entry_count)
);

### tb/binary_min_heap_queue_core_tb.sv
`timescale 1ns / 1ps

module binary_min_heap_queue_core_tb;
    import bmhq_pkg::*;

    localparam int DEPTH        = 256;
    localparam int KEY_W        = 16;
    localparam int TAG_W        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int ITEM_TARGET  = 1900;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [CNT_W-1:0]    count;
    } heap_result_t;

    // Shadow heap plus the words it says the block must return, oldest first.
    class heap_scoreboard;
        logic [KEY_W-1:0] keys [DEPTH];
        logic [TAG_W-1:0] tags [DEPTH];
        int unsigned      held;
        heap_result_t     pending_results [$];
        int unsigned      errors;
        int unsigned      n_insert;
        int unsigned      n_extract;
        int unsigned      n_empty;
        int unsigned      n_full;
        int unsigned      peak;

        function new();
            held      = 0;
            errors    = 0;
            n_insert  = 0;
            n_extract = 0;
            n_empty   = 0;
            n_full    = 0;
            peak      = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [KEY_W-1:0] k;
            logic [TAG_W-1:0] t;
            k       = keys[a];
            t       = tags[a];
            keys[a] = keys[b];
            tags[a] = tags[b];
            keys[b] = k;
            tags[b] = t;
        endfunction

        function void note_input(logic word_op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
            heap_result_t r;
            int unsigned  pos;
            int unsigned  up;
            int unsigned  lc;
            int unsigned  rc;
            int unsigned  best;
            r.status = STATUS_OK;
            r.key    = '0;
            r.tag    = '0;
            if (word_op == OP_INSERT)
            begin
                n_insert++;
                if (held >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    keys[held] = key;
                    tags[held] = tag;
                    pos        = held;
                    held++;
                    // climb while the parent is strictly larger; ties stay put
                    while (pos > 0)
                    begin
                        up = (pos - 1) / 2;
                        if (!(keys[up] > keys[pos]))
                            break;
                        swap_slots(up, pos);
                        pos = up;
                    end
                end
            end
            else
            begin
                n_extract++;
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.key = keys[0];
                    r.tag = tags[0];
                    swap_slots(0, held - 1);
                    held--;
                    pos = 0;
                    // left child first, right only if strictly below the best so far
                    while (pos < held)
                    begin
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        best = pos;
                        if (lc < held && keys[lc] < keys[pos])
                            best = lc;
                        if (rc < held && keys[rc] < keys[best])
                            best = rc;
                        if (best == pos)
                            break;
                        swap_slots(best, pos);
                        pos = best;
                    end
                end
            end
            if (held > peak)
                peak = held;
            r.count = CNT_W'(held);
            pending_results = {pending_results, r};
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("[%0t] heap word mismatch on %s: got %h, want %h", $realtime, field, got, want);
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                          logic [TAG_W-1:0] tag, logic [CNT_W-1:0] count);
            heap_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unrequested word", {16'h0, key}, '0);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", 32'(status), 32'(want.status));
            if (key !== want.key)
                report_mismatch("out_key", 32'(key), 32'(want.key));
            if (tag !== want.tag)
                report_mismatch("out_tag", 32'(tag), 32'(want.tag));
            if (count !== want.count)
                report_mismatch("entry_count", 32'(count), 32'(want.count));
        endtask
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                op         = OP_INSERT;
    logic [KEY_W-1:0]    insert_key = '0;
    logic [TAG_W-1:0]    insert_tag = '0;
    logic                out_valid;
    logic                out_ready  = 1'b1;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [CNT_W-1:0]    entry_count;

    heap_scoreboard sb = new();
    int unsigned    issued = 0;
    int unsigned    cycles = 0;
    logic [7:0]     ready_pattern = 8'hFF;
    int unsigned    ready_phase   = 0;

    binary_min_heap_queue_core #(
        .CAPACITY (DEPTH),
        .KEY_BITS (KEY_W),
        .TAG_BITS (TAG_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .insert_key  (insert_key),
        .insert_tag  (insert_tag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_key     (out_key),
        .out_tag     (out_tag),
        .entry_count (entry_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // values read here are the ones in place at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(op, insert_key, insert_tag);
            if (out_valid && out_ready)
                sb.check_result(status, out_key, out_tag, entry_count);
        end
    end

    // receiver backpressure: an 8-bit pattern, reloaded with all ones or a random value with bit 0 set
    always @(posedge clk)
    begin
        out_ready   <= ready_pattern[ready_phase % 8];
        ready_phase <= ready_phase + 1;
        if (ready_phase % 32 == 31)
        begin
            if ($urandom_range(0, 3) == 0)
                ready_pattern <= 8'hFF;
            else
                ready_pattern <= 8'($urandom) | 8'h01;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d words outstanding",
                     cycles, sb.pending_results.size());
            $display("binary_min_heap_queue_core: mismatch");
            $finish;
        end
    end

    task automatic send_word(logic word_op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
        in_valid   <= 1'b1;
        op         <= word_op;
        insert_key <= key;
        insert_tag <= tag;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic hold_off(int unsigned gap);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    function automatic logic [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 3))
            0:       return KEY_W'($urandom_range(0, 7));   // lots of equal keys
            1:       return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic run_segment(int unsigned len, int unsigned insert_pct);
        int unsigned burst_left;
        logic        word_op;
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++)
        begin
            word_op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_EXTRACT;
            send_word(word_op, draw_key(), TAG_W'($urandom));
            issued++;
            burst_left--;
            if (burst_left == 0)
            begin
                hold_off($urandom_range(1, 8));
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
            end
        end
    endtask

    initial
    begin
        int unsigned pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty extract, extreme keys and tags, a run of ties, drain past empty
        send_word(OP_EXTRACT, 16'h0000, 16'h0000);
        send_word(OP_INSERT,  16'hFFFF, 16'h0000);
        send_word(OP_INSERT,  16'h0000, 16'hFFFF);
        send_word(OP_INSERT,  16'h8000, 16'hA5A5);
        send_word(OP_INSERT,  16'h0005, 16'h0001);
        send_word(OP_INSERT,  16'h0005, 16'h0002);
        send_word(OP_INSERT,  16'h0005, 16'h0003);
        send_word(OP_INSERT,  16'h7FFF, 16'h5A5A);
        send_word(OP_INSERT,  16'h0001, 16'h8001);
        repeat (9) send_word(OP_EXTRACT, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT,  16'hFFFF, 16'hFFFF);
        send_word(OP_EXTRACT, 16'h0000, 16'h0000);
        wait_for_results();

        // fill well past capacity, then drain well past empty
        run_segment(330, 97);
        wait_for_results();
        run_segment(300, 3);

        while (issued < ITEM_TARGET)
        begin
            case ($urandom_range(0, 2))
                0:       pct = 15;
                1:       pct = 50;
                default: pct = 85;
            endcase
            run_segment($urandom_range(40, 200), pct);
            if ($urandom_range(0, 5) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d words: %0d inserts (%0d on a full heap), %0d extracts (%0d on empty)",
                 sb.n_insert + sb.n_extract, sb.n_insert, sb.n_full, sb.n_extract, sb.n_empty);
        $display("deepest heap held %0d entries; %0d field errors", sb.peak, sb.errors);
        if (sb.errors == 0)
            $display("binary_min_heap_queue_core: match");
        else
            $display("binary_min_heap_queue_core: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/binary_min_heap_queue_core.sv
sv/bmhq_checker.sv
tb/binary_min_heap_queue_core_tb.sv
